// ===== rtl/cfe_pkg.sv =====
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types, constants and the tail detector step for the command frame
// extractor.
// ----------------------------------------------------------------------------
package cfe_pkg;

  localparam int POS_W            = 7;
  localparam int DEFAULT_CAPACITY = 64;

  localparam logic [7:0] HEADER_BYTE = 8'hEE;
  localparam logic [7:0] TAIL_A      = 8'hFF;
  localparam logic [7:0] TAIL_B      = 8'hFC;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_READ,
    ST_LOAD,
    ST_OVF
  } ctrl_state_t;

  typedef enum logic [2:0] {
    TS_NONE,
    TS_FF1,
    TS_FC1,
    TS_FF2,
    TS_DONE
  } tail_t;

  typedef struct packed {
    logic take;
    logic rd_issue;
    logic out_load;
    logic out_ovf_load;
    logic frame_clear;
  } cfe_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic frame_ovf;
    logic rd_last;
    logic out_free;
  } cfe_status_t;

  function automatic tail_t next_tail(input tail_t st, input logic [7:0] b);
    tail_t res;
    res = TS_NONE;
    if (b == TAIL_A) begin
      case (st)
        TS_FC1:  res = TS_FF2;
        TS_FF2:  res = TS_DONE;
        default: res = TS_FF1;
      endcase
    end else if (b == TAIL_B) begin
      if (st inside {TS_FF1, TS_FF2}) begin
        res = TS_FC1;
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/command_frame_extractor.sv =====
// ----------------------------------------------------------------------------
// command_frame_extractor
// Received bytes are dropped until a 0xEE header; from the header on each
// byte goes into a frame store of FRAME_CAPACITY bytes while a detector
// watches for the tail FF FC FF FF. On the last tail byte the frame, header
// through tail, is sent out one word per byte with its length and a last
// flag; a frame that outgrew the store gives one word with overflow set,
// byte zero and length FRAME_CAPACITY. While hunting or collecting a byte is
// taken every cycle. Once a tail is seen the input stalls during readout,
// which issues one store read per byte and loads each read byte into the
// output register, holding while the output stalls; an overflow word is
// loaded without store reads. The final word may still wait at the output
// while new bytes are taken.
// ----------------------------------------------------------------------------
module command_frame_extractor #(
  parameter int FRAME_CAPACITY = cfe_pkg::DEFAULT_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_frame_byte,
  output logic [cfe_pkg::POS_W-1:0] out_frame_length,
  output logic                      out_overflow,
  output logic                      out_last
);
  import cfe_pkg::*;

  cfe_cmd_t    cmd;
  cfe_status_t status;

  cfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  cfe_datapath #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_length (out_frame_length),
    .out_overflow     (out_overflow),
    .out_last         (out_last)
  );

`ifndef SYNTH
  // overflow word is always a single, final, zero word
  a_ovf_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_last && (out_frame_byte == 8'h00))
    else $error("overflow word malformed");

  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_frame_length == POS_W'(FRAME_CAPACITY))
    else $error("overflow word length is not the capacity");

  // header plus four tail bytes at least
  a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |-> out_frame_length >= POS_W'(5))
    else $error("frame shorter than header and tail");

  // no input byte taken in while a non-final word is still being read out
  a_stall_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken during frame readout");
`endif

endmodule

// ===== rtl/cfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfe_ctrl
// Controller: hunts and collects, then sequences the frame readout or the
// single overflow word.
// ----------------------------------------------------------------------------
module cfe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  cfe_pkg::cfe_status_t status,
  output cfe_pkg::cfe_cmd_t   cmd,
  output logic                in_stall
);
  import cfe_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_HUNT: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (status.frame_end) begin
          state_nxt = status.frame_ovf ? ST_OVF : ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.rd_last) begin
            cmd.frame_clear = 1'b1;
            state_nxt       = ST_HUNT;
          end else begin
            cmd.rd_issue = 1'b1;
          end
        end
      end
      ST_OVF: begin
        if (status.out_free) begin
          cmd.out_ovf_load = 1'b1;
          cmd.frame_clear  = 1'b1;
          state_nxt        = ST_HUNT;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

endmodule

// ===== rtl/cfe_datapath.sv =====
// ----------------------------------------------------------------------------
// cfe_datapath
// Frame store, position counter, tail detector, readout pointer and the
// output register.
// ----------------------------------------------------------------------------
module cfe_datapath #(
  parameter int FRAME_CAPACITY = cfe_pkg::DEFAULT_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfe_pkg::cfe_cmd_t          cmd,
  output cfe_pkg::cfe_status_t       status,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_frame_byte,
  output logic [cfe_pkg::POS_W-1:0]  out_frame_length,
  output logic                       out_overflow,
  output logic                       out_last
);
  import cfe_pkg::*;

  localparam int              AW    = $clog2(FRAME_CAPACITY);
  localparam logic [POS_W-1:0] CAP_W = POS_W'(FRAME_CAPACITY);

  logic [7:0]       store_mem [FRAME_CAPACITY];
  logic [POS_W-1:0] position_r;
  tail_t            tail_r;
  logic             ovf_r;
  logic [POS_W-1:0] rd_idx_r;
  logic [7:0]       rd_data_r;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic [POS_W-1:0] out_len_r;
  logic             out_ovf_r;
  logic             out_last_r;

  logic  active;
  logic  take;
  logic  store_full;
  tail_t tail_nxt;

  assign active     = (position_r != '0) || (in_rx_byte == HEADER_BYTE);
  assign take       = cmd.take && active;
  assign store_full = (position_r == CAP_W);
  assign tail_nxt   = next_tail(tail_r, in_rx_byte);

  assign status.frame_end = take && (tail_nxt == TS_DONE);
  assign status.frame_ovf = ovf_r || store_full;
  assign status.rd_last   = (rd_idx_r == position_r);
  assign status.out_free  = !out_valid_r || !out_stall;

  // frame state and readout pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      tail_r     <= TS_NONE;
      ovf_r      <= 1'b0;
      rd_idx_r   <= '0;
    end else if (cmd.frame_clear) begin
      position_r <= '0;
      tail_r     <= TS_NONE;
      ovf_r      <= 1'b0;
      rd_idx_r   <= '0;
    end else begin
      if (take) begin
        if (store_full) begin
          ovf_r <= 1'b1;
        end else begin
          position_r <= position_r + POS_W'(1);
        end
        tail_r <= tail_nxt;
      end
      if (cmd.rd_issue) begin
        rd_idx_r <= rd_idx_r + POS_W'(1);
      end
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (take && !store_full) begin
      store_mem[position_r[AW-1:0]] <= in_rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= store_mem[rd_idx_r[AW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load || cmd.out_ovf_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r <= rd_data_r;
      out_len_r  <= position_r;
      out_ovf_r  <= 1'b0;
      out_last_r <= status.rd_last;
    end else if (cmd.out_ovf_load) begin
      out_byte_r <= '0;
      out_len_r  <= CAP_W;
      out_ovf_r  <= 1'b1;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_byte   = out_byte_r;
  assign out_frame_length = out_len_r;
  assign out_overflow     = out_ovf_r;
  assign out_last         = out_last_r;

endmodule

// ===== tb/tb_command_frame_extractor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_frame_extractor
// Feeds received bytes into the frame extractor, from a short table of
// hand-made frames followed by random frames with noise between them. A
// behavioural frame tracker predicts every output word, and each accepted
// word is compared with the oldest prediction. Both handshakes idle at
// random, with one long output hold and a few drain pauses on the way.
// ----------------------------------------------------------------------------
module tb_command_frame_extractor;
  import cfe_pkg::*;

  localparam int FRAME_CAP      = DEFAULT_CAPACITY;
  localparam int NUM_ROWS       = 27;
  localparam int RANDOM_ITEMS   = 160;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 2 * FRAME_CAP + 10;

  typedef struct packed {
    logic [7:0]       fbyte;
    logic [POS_W-1:0] flen;
    logic             ovf;
    logic             lst;
  } frame_word_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    frame_word_t want;
  } stim_row_t;

  localparam frame_word_t NO_WORD = '0;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_frame_byte;
  logic [POS_W-1:0] out_frame_length;
  logic             out_overflow;
  logic             out_last;

  // frame tracker state
  logic [POS_W-1:0] frame_pos = '0;
  tail_t            tail_prog = TS_NONE;
  logic             frame_overrun = 1'b0;
  logic [7:0]       frame_mem [FRAME_CAP];

  frame_word_t pending_words [$];
  frame_word_t got_word;
  frame_word_t want_word;
  stim_row_t   directed_rows [NUM_ROWS];

  int  errors = 0;
  int  framed_bytes = 0;
  int  idle_cycles = 0;
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;

  command_frame_extractor #(
    .FRAME_CAPACITY(FRAME_CAP)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_length (out_frame_length),
    .out_overflow     (out_overflow),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return TAIL_A;
    if (r == 2) return TAIL_B;
    if (r == 3) return HEADER_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic tail_t tail_after(input tail_t st, input logic [7:0] b);
    case (b)
      TAIL_A: begin
        case (st)
          TS_FC1:  return TS_FF2;
          TS_FF2:  return TS_DONE;
          default: return TS_FF1;
        endcase
      end
      TAIL_B: begin
        return (st == TS_FF1 || st == TS_FF2) ? TS_FC1 : TS_NONE;
      end
      default: return TS_NONE;
    endcase
  endfunction

  task automatic flag_error(input string what, input frame_word_t want,
                            input frame_word_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: expected byte %02h len %0d ovf %b last %b, got byte %02h len %0d ovf %b last %b",
               $time, what, want.fbyte, want.flen, want.ovf, want.lst,
               got.fbyte, got.flen, got.ovf, got.lst);
    end
  endtask

  // one accepted byte into the frame tracker, queueing the words it releases
  task automatic absorb_byte(input logic [7:0] b, output int produced);
    frame_word_t w;
    produced = 0;
    if (frame_pos == 0 && b != HEADER_BYTE) return;
    framed_bytes++;
    if (frame_pos < FRAME_CAP) begin
      frame_mem[frame_pos] = b;
      frame_pos++;
    end else begin
      frame_overrun = 1'b1;
    end
    tail_prog = tail_after(tail_prog, b);
    if (tail_prog != TS_DONE) return;
    if (frame_overrun) begin
      w.fbyte = 8'h00;
      w.flen  = POS_W'(FRAME_CAP);
      w.ovf   = 1'b1;
      w.lst   = 1'b1;
      pending_words.push_back(w);
      produced = 1;
    end else begin
      for (int k = 0; k < frame_pos; k++) begin
        w.fbyte = frame_mem[k];
        w.flen  = frame_pos;
        w.ovf   = 1'b0;
        w.lst   = (k == frame_pos - 1);
        pending_words.push_back(w);
      end
      produced = int'(frame_pos);
    end
    frame_pos     = '0;
    tail_prog     = TS_NONE;
    frame_overrun = 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, output int produced);
    int gap;
    in_rx_byte <= b;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    absorb_byte(b, produced);
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic bit is_sized_frame(input int idx);
    return idx == 3 || idx == 8 || idx == 12;
  endfunction

  task automatic send_frame(input int idx);
    int         body_len;
    int         noise;
    int         broken;
    int         produced;
    logic [7:0] b;
    steady = (idx % 7 == 4);
    if (idx == 5 || is_sized_frame(idx)) drain_words();
    case (idx)
      3:       body_len = FRAME_CAP - 5;
      8:       body_len = FRAME_CAP - 4;
      12:      body_len = FRAME_CAP + 6;
      default: body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                      : $urandom_range(0, 10);
    endcase
    noise  = is_sized_frame(idx) ? 0 : $urandom_range(0, 3);
    broken = (is_sized_frame(idx) || is_sized_frame(idx + 1) || idx <= 1)
             ? 7 : $urandom_range(0, 7);
    repeat (noise) send_byte(8'($urandom_range(0, 255)), produced);
    if (broken != 0) send_byte(HEADER_BYTE, produced);
    for (int k = 0; k < body_len; k++) begin
      b = (is_sized_frame(idx) || idx == 1) ? 8'($urandom_range(0, 8'hFB))
                                            : payload_byte();
      send_byte(b, produced);
    end
    send_byte(TAIL_A, produced);
    send_byte(TAIL_B, produced);
    send_byte(TAIL_A, produced);
    // hold the output across this readout while the next frame is offered
    if (idx == 1) hold_req = 1'b1;
    if (broken == 1) send_byte(8'($urandom_range(0, 8'hFE)), produced);
    else send_byte(TAIL_A, produced);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_word = '{out_frame_byte, out_frame_length, out_overflow, out_last};
      if (pending_words.size() == 0) begin
        flag_error("unexpected word", NO_WORD, got_word);
      end else begin
        want_word = pending_words.pop_front();
        if (got_word.fbyte !== want_word.fbyte || got_word.flen !== want_word.flen ||
            got_word.ovf !== want_word.ovf || got_word.lst !== want_word.lst) begin
          flag_error("word mismatch", want_word, got_word);
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // output side
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        n = steady ? 0 : idle_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int produced;
    int idx;
    int counted;
    int mark;
    directed_rows = '{
      // hunting: tail bytes before any header are dropped
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFC, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      // shortest frame
      '{HEADER_BYTE, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFC, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFF, 1'b1, '{8'hFF, 7'd5, 1'b0, 1'b1}},
      // header as payload, tail restarts mid-pattern
      '{HEADER_BYTE, 1'b0, NO_WORD},
      '{HEADER_BYTE, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFC, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFC, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFF, 1'b1, '{8'hFF, 7'd9, 1'b0, 1'b1}},
      // byte extremes, lone fc
      '{HEADER_BYTE, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      '{8'h7F, 1'b0, NO_WORD},
      '{8'h80, 1'b0, NO_WORD},
      '{8'hFC, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFC, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFF, 1'b1, '{8'hFF, 7'd9, 1'b0, 1'b1}}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx, produced);
      if (directed_rows[i].typed) begin
        if (produced == 0) flag_error("frame not closed", directed_rows[i].want, NO_WORD);
        else pending_words[pending_words.size() - 1] = directed_rows[i].want;
      end
    end
    drain_words();

    idx = 0;
    counted = 0;
    while (idx <= 12 || counted < RANDOM_ITEMS) begin
      mark = framed_bytes;
      send_frame(idx);
      if (!is_sized_frame(idx)) counted += framed_bytes - mark;
      idx++;
    end
    steady = 1'b0;

    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
